>>> rtl/core/htd_pkg.sv
// Shared types and constants for the hextile rectangle decoder.
package htd_pkg;

  localparam int unsigned TILE_SIZE       = 16;
  localparam int unsigned MAX_PIXEL_BYTES = 4;

  // register index, byte address is index * 4
  localparam logic REG_BPP = 1'b0;

  // subencoding flag bit positions
  localparam int unsigned FL_RAW      = 0;
  localparam int unsigned FL_BG       = 1;
  localparam int unsigned FL_FG       = 2;
  localparam int unsigned FL_ANY      = 3;
  localparam int unsigned FL_COLOURED = 4;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_SUBENC  = 8'b0000_0010,
    PH_RAW     = 8'b0000_0100,
    PH_BG      = 8'b0000_1000,
    PH_FG      = 8'b0001_0000,
    PH_COUNT   = 8'b0010_0000,
    PH_SUBPIX  = 8'b0100_0000,
    PH_SUBGEOM = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [4:0]  w;
    logic [4:0]  h;
    logic [31:0] colour;
    logic        last;
  } result_t;

endpackage

>>> rtl/core/htd_parser.sv
// Hextile byte parser: tile walk, subencoding state machine and result generation.
module htd_parser import htd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  opcode_e     opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] rect_x_i,
  input  logic [15:0] rect_y_i,
  input  logic [15:0] rect_w_i,
  input  logic [15:0] rect_h_i,
  input  logic [2:0]  bpp_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam logic [4:0]  TileW  = 5'(TILE_SIZE);
  localparam logic [15:0] Tile16 = 16'(TILE_SIZE);
  localparam logic [16:0] Tile17 = 17'(TILE_SIZE);
  localparam logic [2:0]  MaxPix = 3'(MAX_PIXEL_BYTES);

  phase_e      phase_q, phase_d;
  logic [15:0] rx_q, rx_d, ry_q, ry_d, rw_q, rw_d, rh_q, rh_d;
  logic [15:0] tx_q, tx_d, ty_q, ty_d;
  logic [4:0]  tw_q, tw_d, th_q, th_d;
  logic [4:0]  flags_q, flags_d;
  logic [31:0] bg_q, bg_d, fg_q, fg_d, acc_q, acc_d;
  logic [1:0]  bi_q, bi_d;
  logic [8:0]  items_q, items_d;
  logic [3:0]  col_q, col_d, row_q, row_d;

  logic [2:0]  psize;
  logic [31:0] acc_base, acc_new;
  logic        pix_done;
  logic [1:0]  bi_pix;
  logic        final_tile;
  logic [16:0] tx_plus;
  logic [15:0] nxt_tx, nxt_ty, nxt_dw, nxt_dh;
  logic [9:0]  area;
  logic [8:0]  items_dec;
  logic [4:0]  flags_eff;
  logic        do_bg, do_end;

  always_comb begin
    case (bpp_i)
      3'd1:    psize = 3'd1;
      3'd2:    psize = 3'd2;
      default: psize = 3'd4;
    endcase
    if (psize > MaxPix) psize = MaxPix;
  end

  assign acc_base = (bi_q == 2'd0) ? 32'd0 : acc_q;
  assign acc_new  = acc_base | ({24'd0, data_byte_i} << {bi_q, 3'b000});
  assign pix_done = ({1'b0, bi_q} + 3'd1) >= psize;
  assign bi_pix   = pix_done ? 2'd0 : bi_q + 2'd1;

  assign final_tile = ({1'b0, tx_q} + Tile17 >= {1'b0, rw_q}) &&
                      ({1'b0, ty_q} + Tile17 >= {1'b0, rh_q});
  assign tx_plus = {1'b0, tx_q} + Tile17;
  assign nxt_tx  = (tx_plus >= {1'b0, rw_q}) ? 16'd0 : tx_plus[15:0];
  assign nxt_ty  = (tx_plus >= {1'b0, rw_q}) ? ty_q + Tile16 : ty_q;
  assign nxt_dw  = rw_q - nxt_tx;
  assign nxt_dh  = rh_q - nxt_ty;

  assign area      = {5'd0, tw_q} * {5'd0, th_q};
  assign items_dec = items_q - 9'd1;

  always_comb begin
    phase_d = phase_q;
    rx_d = rx_q; ry_d = ry_q; rw_d = rw_q; rh_d = rh_q;
    tx_d = tx_q; ty_d = ty_q; tw_d = tw_q; th_d = th_q;
    flags_d = flags_q;
    bg_d = bg_q; fg_d = fg_q; acc_d = acc_q;
    bi_d = bi_q; items_d = items_q;
    col_d = col_q; row_d = row_q;
    flags_eff = flags_q;
    do_bg = 1'b0;
    do_end = 1'b0;
    res_valid_o = 1'b0;
    res_o.kind = KIND_FILL;
    res_o.x = 16'd0;
    res_o.y = 16'd0;
    res_o.w = 5'd0;
    res_o.h = 5'd0;
    res_o.colour = 32'd0;
    res_o.last = 1'b0;

    if (step_i) begin
      if (opcode_i == OP_START) begin
        rx_d = rect_x_i; ry_d = rect_y_i; rw_d = rect_w_i; rh_d = rect_h_i;
        tx_d = 16'd0; ty_d = 16'd0;
        bi_d = 2'd0;
        items_d = 9'd0;
        if (rect_w_i == 16'd0 || rect_h_i == 16'd0) begin
          phase_d = PH_IDLE;
          tw_d = 5'd0;
          th_d = 5'd0;
          res_valid_o = 1'b1;
          res_o.kind = KIND_DONE;
          res_o.last = 1'b1;
        end else begin
          tw_d = (rect_w_i < Tile16) ? rect_w_i[4:0] : TileW;
          th_d = (rect_h_i < Tile16) ? rect_h_i[4:0] : TileW;
          phase_d = PH_SUBENC;
        end
      end else begin
        case (phase_q)
          PH_SUBENC: begin
            flags_d = data_byte_i[4:0];
            flags_eff = data_byte_i[4:0];
            bi_d = 2'd0;
            if (data_byte_i[FL_RAW]) begin
              items_d = area[8:0];
              col_d = 4'd0;
              row_d = 4'd0;
              phase_d = PH_RAW;
            end else if (data_byte_i[FL_BG]) begin
              phase_d = PH_BG;
            end else begin
              do_bg = 1'b1;
            end
          end
          PH_RAW: begin
            acc_d = acc_new;
            bi_d = bi_pix;
            if (pix_done) begin
              items_d = items_dec;
              res_valid_o = 1'b1;
              res_o.kind = KIND_PIXEL;
              res_o.x = rx_q + tx_q + {12'd0, col_q};
              res_o.y = ry_q + ty_q + {12'd0, row_q};
              res_o.w = 5'd1;
              res_o.h = 5'd1;
              res_o.colour = acc_new;
              res_o.last = (items_dec == 9'd0) && final_tile;
              if ({1'b0, col_q} + 5'd1 == tw_q) begin
                col_d = 4'd0;
                row_d = row_q + 4'd1;
              end else begin
                col_d = col_q + 4'd1;
              end
              if (items_dec == 9'd0) do_end = 1'b1;
            end
          end
          PH_BG: begin
            acc_d = acc_new;
            bi_d = bi_pix;
            if (pix_done) begin
              bg_d = acc_new;
              do_bg = 1'b1;
            end
          end
          PH_FG: begin
            acc_d = acc_new;
            bi_d = bi_pix;
            if (pix_done) begin
              fg_d = acc_new;
              if (flags_q[FL_ANY]) phase_d = PH_COUNT;
              else do_end = 1'b1;
            end
          end
          PH_COUNT: begin
            items_d = {1'b0, data_byte_i};
            if (data_byte_i == 8'd0) begin
              do_end = 1'b1;
              if (final_tile) begin
                res_valid_o = 1'b1;
                res_o.kind = KIND_DONE;
                res_o.last = 1'b1;
              end
            end else begin
              bi_d = 2'd0;
              phase_d = flags_q[FL_COLOURED] ? PH_SUBPIX : PH_SUBGEOM;
            end
          end
          PH_SUBPIX: begin
            acc_d = acc_new;
            bi_d = bi_pix;
            if (pix_done) begin
              fg_d = acc_new;
              phase_d = PH_SUBGEOM;
              bi_d = 2'd0;
            end
          end
          PH_SUBGEOM: begin
            if (bi_q == 2'd0) begin
              acc_d = {24'd0, data_byte_i};
              bi_d = 2'd1;
            end else begin
              items_d = items_dec;
              res_valid_o = 1'b1;
              res_o.kind = KIND_FILL;
              res_o.x = rx_q + tx_q + {12'd0, acc_q[7:4]};
              res_o.y = ry_q + ty_q + {12'd0, acc_q[3:0]};
              res_o.w = {1'b0, data_byte_i[7:4]} + 5'd1;
              res_o.h = {1'b0, data_byte_i[3:0]} + 5'd1;
              res_o.colour = fg_q;
              res_o.last = (items_dec == 9'd0) && final_tile;
              if (items_dec == 9'd0) begin
                do_end = 1'b1;
              end else begin
                bi_d = 2'd0;
                phase_d = flags_q[FL_COLOURED] ? PH_SUBPIX : PH_SUBGEOM;
              end
            end
          end
          default: ;
        endcase

        if (do_bg) begin
          res_valid_o = 1'b1;
          res_o.kind = KIND_FILL;
          res_o.x = rx_q + tx_q;
          res_o.y = ry_q + ty_q;
          res_o.w = tw_q;
          res_o.h = th_q;
          res_o.colour = bg_d;
          res_o.last = final_tile && !flags_eff[FL_ANY];
          bi_d = 2'd0;
          if (flags_eff[FL_FG]) phase_d = PH_FG;
          else if (flags_eff[FL_ANY]) phase_d = PH_COUNT;
          else do_end = 1'b1;
        end

        if (do_end) begin
          if (final_tile) begin
            phase_d = PH_IDLE;
          end else begin
            tx_d = nxt_tx;
            ty_d = nxt_ty;
            tw_d = (nxt_dw < Tile16) ? nxt_dw[4:0] : TileW;
            th_d = (nxt_dh < Tile16) ? nxt_dh[4:0] : TileW;
            phase_d = PH_SUBENC;
            bi_d = 2'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rx_q <= '0; ry_q <= '0; rw_q <= '0; rh_q <= '0;
      tx_q <= '0; ty_q <= '0; tw_q <= '0; th_q <= '0;
      flags_q <= '0;
      bg_q <= '0; fg_q <= '0; acc_q <= '0;
      bi_q <= '0; items_q <= '0;
      col_q <= '0; row_q <= '0;
    end else begin
      phase_q <= phase_d;
      rx_q <= rx_d; ry_q <= ry_d; rw_q <= rw_d; rh_q <= rh_d;
      tx_q <= tx_d; ty_q <= ty_d; tw_q <= tw_d; th_q <= th_d;
      flags_q <= flags_d;
      bg_q <= bg_d; fg_q <= fg_d; acc_q <= acc_d;
      bi_q <= bi_d; items_q <= items_d;
      col_q <= col_d; row_q <= row_d;
    end
  end

`ifndef SYNTHESIS
  a_raw_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RAW) |-> (items_q != 9'd0))
    else $error("raw tile with no pixels left");

  a_tile_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (tw_q != 5'd0 && tw_q <= TileW && th_q != 5'd0 && th_q <= TileW))
    else $error("tile size out of range");

  a_raw_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RAW) |-> ({1'b0, col_q} < tw_q))
    else $error("raw column beyond tile width");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_DONE) |-> res_o.last)
    else $error("done result not marked last");
`endif

endmodule

>>> rtl/core/hextile_rectangle_decoder_top.sv
// Top level of the hextile rectangle decoder: stream ports, config register, output stage.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tuser opcode, tdata byte + rectangle
//  m_axis    out  m_axis_tvalid/tready        tuser kind, tlast last, tdata result
//  apb       in   psel/penable/pwrite/pready  bytes_per_pixel at address 0
//
// One transaction per cycle in while s_axis_tready is high and at most one result per
// transaction; the parser state updates in the accepting cycle and the result lands in
// the output register. s_axis_tready drops only while a result waits and m_axis_tready
// is low. Reset clears the parser to idle, the colours to zero and bytes_per_pixel to 4.
module hextile_rectangle_decoder_top import htd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte, [23:8] rect_x, [39:24] rect_y, [55:40] rect_w, [71:56] rect_h
  input  logic [71:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_x, [31:16] out_y, [36:32] out_w, [41:37] out_h, [73:42] colour, rest zero
  output logic [79:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] bpp_q;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BPP) ? {29'd0, bpp_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= 3'd4;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BPP) begin
      bpp_q <= pwdata[2:0];
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  htd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .opcode_i    (opcode_e'(s_axis_tuser)),
    .data_byte_i (s_axis_tdata[7:0]),
    .rect_x_i    (s_axis_tdata[23:8]),
    .rect_y_i    (s_axis_tdata[39:24]),
    .rect_w_i    (s_axis_tdata[55:40]),
    .rect_h_i    (s_axis_tdata[71:56]),
    .bpp_i       (bpp_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'd0, out_q.colour, out_q.h, out_q.w, out_q.y, out_q.x};

endmodule
